// ===== rtl/aus_pkg.sv =====
// ----------------------------------------------------------------------------
// aus_pkg: shared types and constants for the unsigned add/sub/mul unit
// Operand and result widths, operation codes and the word that moves
// from cell to cell along the multiplier chain.
// ----------------------------------------------------------------------------
package aus_pkg;

	// operand width of the arithmetic
	localparam int WIDTH = 16;
	// widths of the ports
	localparam int OPND_W = 16;
	localparam int RES_W  = 32;
	localparam int OP_W   = 2;
	// bits of each operand that take part
	localparam int USE_W  = (WIDTH < OPND_W) ? WIDTH : OPND_W;
	// width of the full product
	localparam int PROD_W = 2 * USE_W;

	localparam logic [OP_W-1:0] OP_ADD = 2'd0;
	localparam logic [OP_W-1:0] OP_SUB = 2'd1;
	localparam logic [OP_W-1:0] OP_MUL = 2'd2;

	// word handed from one cell to the next
	typedef struct packed {
		logic              valid;
		logic              mul;
		logic              flag;
		logic [PROD_W-1:0] acc;
		logic [PROD_W-1:0] partial;
		logic [USE_W-1:0]  mult;
	} aus_stage_t;

endpackage

// ===== rtl/unsigned_add_sub_mul_unit.sv =====
// ----------------------------------------------------------------------------
// unsigned_add_sub_mul_unit: unsigned add, subtract and multiply
// Add and subtract are resolved on entry; multiply runs through a chain
// of shift-and-add cells, one multiplier bit per cell.
// ----------------------------------------------------------------------------
// Usage:
//   input channel in_valid/in_ready carries op, operand_a, operand_b;
//   output channel out_valid/out_ready carries result_value, carry_flag.
//   op add gives the sum and its carry out, op sub the difference modulo
//   2^WIDTH and the final borrow, op mul the full product with flag 0,
//   the unused code gives zero.
//   Every op takes the same path through all cells: each word passes one
//   cell per cycle while the chain advances, one cell per multiplier bit,
//   and the last cell's register is the output register.
//   Throughput is one word per cycle while the output is not stalled; all
//   cells advance together.
//   When the receiver stalls with a word waiting at the output, the whole
//   chain holds and in_ready drops; in_ready is high whenever the output
//   is empty or being taken.
//   Reset clears all cells; the unit is ready right after reset.
// ----------------------------------------------------------------------------
module unsigned_add_sub_mul_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [aus_pkg::OP_W-1:0]    op,
	input  logic [aus_pkg::OPND_W-1:0]  operand_a,
	input  logic [aus_pkg::OPND_W-1:0]  operand_b,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [aus_pkg::RES_W-1:0]   result_value,
	output logic                        carry_flag
);

	localparam int N = aus_pkg::USE_W;

	aus_pkg::aus_stage_t chain [0:N];
	logic                advance;
	logic [N-1:0]        a_use;
	logic [N-1:0]        b_use;
	logic [N:0]          sum;
	logic [N:0]          diff;

	assign advance  = !chain[N].valid || out_ready;
	assign in_ready = advance;

	assign a_use = operand_a[N-1:0];
	assign b_use = operand_b[N-1:0];
	assign sum   = {1'b0, a_use} + {1'b0, b_use};
	// top bit of the wide difference is the borrow
	assign diff  = {1'b0, a_use} - {1'b0, b_use};

	always_comb begin
		chain[0].valid   = in_valid;
		chain[0].mul     = 1'b0;
		chain[0].flag    = 1'b0;
		chain[0].acc     = '0;
		chain[0].partial = aus_pkg::PROD_W'(a_use);
		chain[0].mult    = b_use;
		unique case (op)
			aus_pkg::OP_ADD: begin
				chain[0].acc  = aus_pkg::PROD_W'(sum[N-1:0]);
				chain[0].flag = sum[N];
			end
			aus_pkg::OP_SUB: begin
				chain[0].acc  = aus_pkg::PROD_W'(diff[N-1:0]);
				chain[0].flag = diff[N];
			end
			aus_pkg::OP_MUL: begin
				chain[0].mul = 1'b1;
			end
			default: begin
				chain[0].acc = '0;
			end
		endcase
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		aus_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (advance),
			.d      (chain[i]),
			.q      (chain[i+1])
		);
	end

	assign out_valid    = chain[N].valid;
	assign result_value = aus_pkg::RES_W'(chain[N].acc);
	assign carry_flag   = chain[N].flag;

endmodule

// ===== rtl/aus_cell.sv =====
// ----------------------------------------------------------------------------
// aus_cell: one shift-and-add step of the multiplier chain
// For a multiply word, adds the shifted multiplicand into the accumulator
// when the low multiplier bit is set; every word has both shifted for the next cell.
// ----------------------------------------------------------------------------
module aus_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  aus_pkg::aus_stage_t d,
	output aus_pkg::aus_stage_t q
);

	aus_pkg::aus_stage_t nxt;

	always_comb begin
		nxt = d;
		if (d.mul && d.mult[0]) begin
			nxt.acc = d.acc + d.partial;
		end
		nxt.partial = {d.partial[aus_pkg::PROD_W-2:0], 1'b0};
		nxt.mult    = {1'b0, d.mult[aus_pkg::USE_W-1:1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q <= nxt;
		end
	end

endmodule

// ===== rtl/aus_checker.sv =====
// ----------------------------------------------------------------------------
// aus_checker: port-level checks for the unsigned add/sub/mul unit
// Watches the handshake and flow control seen at the top-level ports.
// ----------------------------------------------------------------------------
module aus_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [aus_pkg::RES_W-1:0]   result_value,
	input logic                        carry_flag
);

	// reset empties the chain, so out_valid is low in the cycle after reset is seen
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("out_valid high right after reset");

	// an empty output never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("in_ready low with empty output");

	// a stalled output word holds the whole chain
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	// stalled word stays put
	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_value)
			&& $stable(carry_flag))
		else $error("output word changed under stall");

endmodule

bind unsigned_add_sub_mul_unit aus_checker u_aus_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.result_value (result_value),
	.carry_flag   (carry_flag)
);

// ===== verif/aus_result_checker.sv =====
// ----------------------------------------------------------------------------
// aus_result_checker: scoreboard for the unsigned add/sub/mul unit
// Watches both channels, works out the expected sum, difference or product
// for each word taken in, and compares every word given out against the
// oldest one still owed. Reports a running count of failures.
// ----------------------------------------------------------------------------
module aus_result_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic [aus_pkg::OP_W-1:0]   op,
	input  logic [aus_pkg::OPND_W-1:0] operand_a,
	input  logic [aus_pkg::OPND_W-1:0] operand_b,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic [aus_pkg::RES_W-1:0]  result_value,
	input  logic                       carry_flag,
	output int                         fail_count,
	output int                         words_owed
);

	typedef struct packed {
		logic [aus_pkg::RES_W-1:0] value;
		logic                      flag;
	} answer_t;

	answer_t owed_answers[$];

	function automatic answer_t compute_answer(input logic [aus_pkg::OP_W-1:0] code,
			input logic [aus_pkg::OPND_W-1:0] a_in,
			input logic [aus_pkg::OPND_W-1:0] b_in);
		logic [63:0] mask;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] full;
		answer_t     ans;
		mask = (64'd1 << aus_pkg::WIDTH) - 64'd1;
		a = 64'(a_in) & mask;
		b = 64'(b_in) & mask;
		ans = '0;
		case (code)
			aus_pkg::OP_ADD: begin
				full = a + b;
				ans.value = aus_pkg::RES_W'(full & mask);
				ans.flag = (full > mask);
			end
			aus_pkg::OP_SUB: begin
				ans.value = aus_pkg::RES_W'((a - b) & mask);
				// borrow out of the top bit
				ans.flag = (a < b);
			end
			aus_pkg::OP_MUL: begin
				ans.value = aus_pkg::RES_W'(a * b);
			end
			default: begin
				ans = '0;
			end
		endcase
		return ans;
	endfunction

	always @(posedge clk) begin
		answer_t want;
		if (arst_n) begin
			// result side first: a word leaving now was owed before this edge
			if (out_valid && out_ready) begin
				if (owed_answers.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected word: value %h flag %b", result_value, carry_flag);
					fail_count <= fail_count + 1;
				end else begin
					want = owed_answers.pop_front();
					if (result_value !== want.value || carry_flag !== want.flag) begin
						if (fail_count < 10)
							$display("mismatch: value %h flag %b, expected value %h flag %b",
								result_value, carry_flag, want.value, want.flag);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && in_ready)
				owed_answers = {owed_answers, compute_answer(op, operand_a, operand_b)};
			words_owed <= owed_answers.size();
		end
	end

endmodule

// ===== verif/unsigned_add_sub_mul_unit_test.sv =====
// ----------------------------------------------------------------------------
// unsigned_add_sub_mul_unit_test: testbench top for the add/sub/mul unit
// Sends a directed set of operand extremes for every operation, then random
// words under several sender and receiver idling patterns. The checker next
// to the unit predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module unsigned_add_sub_mul_unit_test;

	localparam logic [aus_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_WORDS = 220;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic [aus_pkg::OP_W-1:0]   op = '0;
	logic [aus_pkg::OPND_W-1:0] operand_a = '0;
	logic [aus_pkg::OPND_W-1:0] operand_b = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [aus_pkg::RES_W-1:0]  result_value;
	logic                       carry_flag;

	int fail_count;
	int words_owed;
	int quiet_cycles = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int sender_idle[4] = '{0, 61, 0, 12};
	int receiver_stall[4] = '{0, 0, 61, 12};

	unsigned_add_sub_mul_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.operand_a(operand_a),
		.operand_b(operand_b),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_value(result_value),
		.carry_flag(carry_flag)
	);

	aus_result_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.operand_a(operand_a),
		.operand_b(operand_b),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_value(result_value),
		.carry_flag(carry_flag),
		.fail_count(fail_count),
		.words_owed(words_owed)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// ends a hung run: nothing taken in or given out for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_word(input logic [aus_pkg::OP_W-1:0] code,
			input logic [aus_pkg::OPND_W-1:0] a, input logic [aus_pkg::OPND_W-1:0] b);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= code;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// mix of all-zero, all-one, walking bits and plain random values
	function automatic logic [aus_pkg::OPND_W-1:0] random_operand();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return aus_pkg::OPND_W'(1) << $urandom_range(aus_pkg::OPND_W - 1);
			3: return ~(aus_pkg::OPND_W'(1) << $urandom_range(aus_pkg::OPND_W - 1));
			default: return aus_pkg::OPND_W'($urandom);
		endcase
	endfunction

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(aus_pkg::OP_ADD, 16'h0000, 16'h0000);
		send_word(aus_pkg::OP_ADD, 16'hFFFF, 16'hFFFF);
		send_word(aus_pkg::OP_ADD, 16'hFFFF, 16'h0001);
		send_word(aus_pkg::OP_ADD, 16'h8000, 16'h8000);
		send_word(aus_pkg::OP_ADD, 16'h7FFF, 16'h8000);
		send_word(aus_pkg::OP_SUB, 16'h0000, 16'h0000);
		send_word(aus_pkg::OP_SUB, 16'h0000, 16'h0001);
		send_word(aus_pkg::OP_SUB, 16'hFFFF, 16'hFFFF);
		send_word(aus_pkg::OP_SUB, 16'h1234, 16'h5678);
		send_word(aus_pkg::OP_SUB, 16'h5678, 16'h1234);
		send_word(aus_pkg::OP_SUB, 16'h0000, 16'hFFFF);
		send_word(aus_pkg::OP_MUL, 16'h0000, 16'hFFFF);
		send_word(aus_pkg::OP_MUL, 16'hFFFF, 16'hFFFF);
		send_word(aus_pkg::OP_MUL, 16'hFFFF, 16'h0001);
		send_word(aus_pkg::OP_MUL, 16'h8000, 16'h0002);
		send_word(aus_pkg::OP_MUL, 16'hAAAA, 16'h5555);
		send_word(aus_pkg::OP_MUL, 16'h0001, 16'h0000);
		send_word(OP_UNUSED, 16'hFFFF, 16'hFFFF);
		send_word(OP_UNUSED, 16'h0000, 16'h0000);
		send_word(OP_UNUSED, 16'h1234, 16'hABCD);

		for (int phase = 0; phase < 4; phase++) begin
			idle_pct = sender_idle[phase];
			stall_pct = receiver_stall[phase];
			repeat (PHASE_WORDS)
				send_word(aus_pkg::OP_W'($urandom_range(3)), random_operand(),
					random_operand());
		end
		in_valid <= 1'b0;
		// let the count of owed words take in the last word
		@(posedge clk);

		while (words_owed != 0)
			@(posedge clk);
		repeat (2 * aus_pkg::WIDTH + 8) @(posedge clk);

		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/aus_pkg.sv
rtl/aus_cell.sv
rtl/unsigned_add_sub_mul_unit.sv
rtl/aus_checker.sv
verif/aus_result_checker.sv
verif/unsigned_add_sub_mul_unit_test.sv
